// ===== src/line_raster_depth_intensity_core_defines.svh =====
// assertion macros shared by the line raster core modules
// no dependencies; included by the files that carry assertions
`ifndef LINE_RASTER_DEPTH_INTENSITY_CORE_DEFINES_SVH
`define LINE_RASTER_DEPTH_INTENSITY_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define LRDI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define LRDI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lrdi_pkg.sv =====
// shared codes, constants and types of the line raster core
// no dependencies
`default_nettype none
package lrdi_pkg;
   // item opcodes, also used as queue entry kinds
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_BUF_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BUF_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_EN   = 2'd2;
   localparam int CSR_DATA_W = 13;
   localparam int BUF_W      = 13;
   localparam logic [BUF_W-1:0] BUF_RESET = 13'd1024;

   // emit phases of a line
   localparam logic [1:0] PH_A    = 2'd0;
   localparam logic [1:0] PH_B    = 2'd1;
   localparam logic [1:0] PH_WALK = 2'd2;

   // intensity and colour formats
   localparam int INTEN_W = 9;
   localparam logic [INTEN_W-1:0] INTEN_MAX = 9'd256;
   localparam int CH_W    = 8;
   localparam int COLOR_W = 24;

   // divider status seen by the front
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage
`default_nettype wire

// ===== src/lrdi_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
// depends on lrdi_pkg
`default_nettype none
module lrdi_div #(
   parameter int DW = 28,
   parameter int LW = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [LW-1:0] divisor,
   output logic [DW-1:0]      quotient,
   output lrdi_pkg::div_stat_type stat
);
   localparam int CNT_W = $clog2(DW + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [LW-1:0]    rem_ff, rem_in;
   logic [LW-1:0]    div_ff, div_in;
   logic             done_ff, done_in;
   logic [LW:0]      trial;

   // operand load on start, else one shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(DW);
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = LW'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[LW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
endmodule
`default_nettype wire

// ===== src/lrdi_fifo.sv =====
// two-entry queue between front and back
// depends on line_raster_depth_intensity_core_defines.svh
`default_nettype none
`include "line_raster_depth_intensity_core_defines.svh"
module lrdi_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   `LRDI_ASSERT_IMP(a_no_overflow, clock, reset, push, count_ff != 2'd2, "push into full queue")
   `LRDI_ASSERT_IMP(a_no_underflow, clock, reset, pop, count_ff != 2'd0, "pop from empty queue")
   `LRDI_ASSERT_NEXT(a_fill_kept, clock, reset, push && !pop, count_ff != 2'd0, "pushed entry lost")
endmodule
`default_nettype wire

// ===== src/lrdi_front.sv =====
// front: accepts items, classifies lines and computes slopes with the divider
// depends on lrdi_pkg, lrdi_div and the defines header
`default_nettype none
`include "line_raster_depth_intensity_core_defines.svh"
module lrdi_front #(
   parameter int C = 12,
   parameter int F = 16,
   parameter int D = 16,
   parameter int EW = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   input  wire logic signed [C-1:0]   req_a_col,
   input  wire logic signed [C-1:0]   req_a_row,
   input  wire logic signed [D-1:0]   req_a_depth,
   input  wire logic signed [C-1:0]   req_b_col,
   input  wire logic signed [C-1:0]   req_b_row,
   input  wire logic signed [D-1:0]   req_b_depth,
   input  wire logic [8:0]            req_a_intensity,
   input  wire logic [8:0]            req_b_intensity,
   input  wire logic [23:0]           req_base_color,
   input  wire logic signed [C:0]     req_offset_col,
   input  wire logic signed [C:0]     req_offset_row,
   output logic                       q_push,
   output logic [EW-1:0]              q_data,
   input  wire logic                  q_full
);
   localparam int DW = ((C > D) ? C : D) + F;
   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;
   localparam logic [1:0] SEL_MINOR = 2'd0;
   localparam logic [1:0] SEL_DEPTH = 2'd1;
   localparam logic [1:0] SEL_INTEN = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic       go_ff, go_in;

   logic [C-1:0]  a_col_ff, a_row_ff, b_col_ff, b_row_ff;
   logic [D-1:0]  a_dep_ff, b_dep_ff;
   logic [F:0]    a_int_ff, b_int_ff;
   logic [23:0]   color_ff;
   logic [C:0]    offc_ff, offr_ff;
   logic          mic_ff, swap_ff;
   logic [C-1:0]  len_ff, mag_min_ff;
   logic [D-1:0]  mag_dep_ff;
   logic [F:0]    mag_int_ff;
   logic          neg_min_ff, neg_dep_ff, neg_int_ff;
   logic [F+1:0]  min_step_ff, min_step_in;
   logic [D+F+1:0] dep_step_ff, dep_step_in;
   logic [F+1:0]  int_step_ff, int_step_in;

   logic [8:0]    ia_c, ib_c;
   logic [F:0]    ia_fx, ib_fx;
   logic [C:0]    dc, dr;
   logic [C-1:0]  adc, adr;
   logic [D:0]    dd;
   logic [9:0]    di;
   logic [8:0]    mag_di;
   logic          mic, swap;
   logic          accept, acc_start, acc_tick;
   logic [DW-1:0] dividend, quotient;
   logic          len_zero;
   lrdi_pkg::div_stat_type div_stat;

   // classify the line from the incoming item
   always_comb begin
      ia_c  = (req_a_intensity > lrdi_pkg::INTEN_MAX) ? lrdi_pkg::INTEN_MAX : req_a_intensity;
      ib_c  = (req_b_intensity > lrdi_pkg::INTEN_MAX) ? lrdi_pkg::INTEN_MAX : req_b_intensity;
      ia_fx = (F+1)'(ia_c) << (F - 8);
      ib_fx = (F+1)'(ib_c) << (F - 8);
      dc    = {req_b_col[C-1], req_b_col} - {req_a_col[C-1], req_a_col};
      dr    = {req_b_row[C-1], req_b_row} - {req_a_row[C-1], req_a_row};
      adc   = dc[C] ? C'(-dc) : dc[C-1:0];
      adr   = dr[C] ? C'(-dr) : dr[C-1:0];
      mic   = !(adr > adc);
      swap  = mic ? dc[C] : dr[C];
      dd    = {req_b_depth[D-1], req_b_depth} - {req_a_depth[D-1], req_a_depth};
      di    = {1'b0, ib_c} - {1'b0, ia_c};
      mag_di = di[9] ? 9'(-di) : di[8:0];
   end

   assign req_ready = (state_ff == F_IDLE) && !q_full;
   assign accept    = req_valid && req_ready;
   assign acc_start = accept && (req_op == lrdi_pkg::OP_START);
   assign acc_tick  = accept && (req_op == lrdi_pkg::OP_TICK);

   // divider operand select
   always_comb begin
      unique case (sel_ff)
         SEL_MINOR: dividend = DW'({mag_min_ff, {F{1'b0}}});
         SEL_DEPTH: dividend = DW'({mag_dep_ff, {F{1'b0}}});
         default:   dividend = DW'(mag_int_ff);
      endcase
   end

   lrdi_div #(.DW(DW), .LW(C)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff),
      .dividend (dividend),
      .divisor  (len_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign len_zero = (len_ff == '0);

   // signed slopes from the unsigned quotient
   always_comb begin
      min_step_in = min_step_ff;
      dep_step_in = dep_step_ff;
      int_step_in = int_step_ff;
      if (div_stat.done) begin
         unique case (sel_ff)
            SEL_MINOR: begin
               min_step_in = len_zero ? '0 : (F+2)'(quotient[F:0]);
               if (neg_min_ff) min_step_in = -min_step_in;
            end
            SEL_DEPTH: begin
               dep_step_in = len_zero ? '0 : (D+F+2)'(quotient);
               if (neg_dep_ff) dep_step_in = -dep_step_in;
            end
            default: begin
               int_step_in = len_zero ? '0 : (F+2)'(quotient[F:0]);
               if (neg_int_ff) int_step_in = -int_step_in;
            end
         endcase
      end
   end

   // sequencer over the three divisions
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      go_in    = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (acc_start) begin
               state_in = F_DIV;
               sel_in   = SEL_MINOR;
               go_in    = 1'b1;
            end
         end
         F_DIV: begin
            if (div_stat.done) begin
               if (sel_ff == SEL_INTEN) begin
                  state_in = F_PUSH;
               end else begin
                  sel_in = sel_ff + 2'd1;
                  go_in  = 1'b1;
               end
            end
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         sel_ff   <= SEL_MINOR;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         go_ff    <= go_in;
      end
      min_step_ff <= min_step_in;
      dep_step_ff <= dep_step_in;
      int_step_ff <= int_step_in;
      if (acc_start) begin
         a_col_ff   <= req_a_col;
         a_row_ff   <= req_a_row;
         a_dep_ff   <= req_a_depth;
         b_col_ff   <= req_b_col;
         b_row_ff   <= req_b_row;
         b_dep_ff   <= req_b_depth;
         a_int_ff   <= ia_fx;
         b_int_ff   <= ib_fx;
         color_ff   <= req_base_color;
         offc_ff    <= req_offset_col;
         offr_ff    <= req_offset_row;
         mic_ff     <= mic;
         swap_ff    <= swap;
         len_ff     <= mic ? adc : adr;
         mag_min_ff <= mic ? adr : adc;
         neg_min_ff <= (mic ? dr[C] : dc[C]) ^ swap;
         mag_dep_ff <= dd[D] ? D'(-dd) : dd[D-1:0];
         neg_dep_ff <= dd[D] ^ swap;
         mag_int_ff <= (F+1)'(mag_di) << (F - 8);
         neg_int_ff <= di[9] ^ swap;
      end
   end

   // queue transfer: ticks pass straight, starts after the slopes
   assign q_push = acc_tick || ((state_ff == F_PUSH) && !q_full);
   assign q_data = acc_tick ? {lrdi_pkg::OP_TICK, (EW-1)'(0)} :
                   {lrdi_pkg::OP_START, a_col_ff, a_row_ff, a_dep_ff, a_int_ff,
                    b_col_ff, b_row_ff, b_dep_ff, b_int_ff, color_ff, offc_ff, offr_ff,
                    mic_ff, swap_ff, min_step_ff, dep_step_ff, int_step_ff};

   `LRDI_ASSERT_IMP(a_done_in_div, clock, reset, div_stat.done, state_ff == F_DIV, "divider done outside division")
endmodule
`default_nettype wire

// ===== src/lrdi_back.sv =====
// back: walks the line and produces one registered pixel per tick on an active line
// depends on lrdi_pkg and the defines header
`default_nettype none
`include "line_raster_depth_intensity_core_defines.svh"
module lrdi_back #(
   parameter int C = 12,
   parameter int F = 16,
   parameter int D = 16,
   parameter int EW = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_index,
   input  wire logic [12:0]          csr_wdata,
   input  wire logic                 q_empty,
   input  wire logic [EW-1:0]        q_data,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [C+1:0]       rsp_pix_col,
   output logic signed [C+1:0]       rsp_pix_row,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic signed [D-1:0]       rsp_depth,
   output logic                      rsp_visible,
   output logic                      rsp_depth_write,
   output logic                      rsp_last
);
   localparam int CW  = C + 2;
   localparam int MW  = C + F + 3;
   localparam int DAW = D + F + 2;
   localparam int IAW = F + 3;
   localparam int VW  = (CW > lrdi_pkg::BUF_W) ? CW : lrdi_pkg::BUF_W;

   // unpacked queue entry
   logic          e_kind;
   logic [C-1:0]  e_a_col, e_a_row, e_b_col, e_b_row;
   logic [D-1:0]  e_a_dep, e_b_dep;
   logic [F:0]    e_a_int, e_b_int;
   logic [23:0]   e_color;
   logic [C:0]    e_offc, e_offr;
   logic          e_mic, e_swap;
   logic [F+1:0]  e_min_step, e_int_step;
   logic [D+F+1:0] e_dep_step;

   assign {e_kind, e_a_col, e_a_row, e_a_dep, e_a_int, e_b_col, e_b_row, e_b_dep, e_b_int,
           e_color, e_offc, e_offr, e_mic, e_swap, e_min_step, e_dep_step,
           e_int_step} = q_data;

   // configuration registers
   logic [12:0] bw_ff, bh_ff;
   logic        den_ff;

   // line state
   logic           active_ff, active_in;
   logic [1:0]     phase_ff, phase_in;
   logic           mic_ff, mic_in;
   logic [C:0]     mpos_ff, mpos_in, mend_ff, mend_in;
   logic [MW-1:0]  macc_ff, macc_in;
   logic [DAW-1:0] dacc_ff, dacc_in;
   logic [IAW-1:0] iacc_ff, iacc_in;
   logic [F+1:0]   mstep_ff, mstep_in, istep_ff, istep_in;
   logic [DAW-1:0] dstep_ff, dstep_in;
   logic [C-1:0]   ep_col_ff [2], ep_row_ff [2];
   logic [D-1:0]   ep_dep_ff [2];
   logic [F:0]     ep_int_ff [2];
   logic [23:0]    color_ff;
   logic [C:0]     offc_ff, offr_ff;

   // output register
   logic           ov_ff, ov_in;
   logic [CW-1:0]  o_col_ff, o_row_ff;
   logic [7:0]     o_r_ff, o_g_ff, o_b_ff;
   logic [D-1:0]   o_dep_ff;
   logic           o_vis_ff, o_dw_ff, o_last_ff;

   logic           take, is_start, emit;
   logic           lo;
   logic [C-1:0]   lo_col, lo_row, hi_col, hi_row, lo_minor;
   logic           sel;
   logic [F:0]     iclamp, pix_int;
   logic [MW-1:0]  msum, mbias;
   logic [DAW-1:0] dbias;
   logic [CW-1:0]  pcol, prow, minor_pix, major_pix;
   logic [D-1:0]   pdep;
   logic           plast, pvis;
   logic [F+8:0]   pr, pg, pb;

   assign take     = !q_empty && (!ov_ff || rsp_ready);
   assign q_pop    = take;
   assign is_start = (e_kind == lrdi_pkg::OP_START);
   assign emit     = take && !is_start && active_ff;

   // low end of the new line along the major axis
   always_comb begin
      lo     = e_swap;
      lo_col = lo ? e_b_col : e_a_col;
      lo_row = lo ? e_b_row : e_a_row;
      hi_col = lo ? e_a_col : e_b_col;
      hi_row = lo ? e_a_row : e_b_row;
      lo_minor = e_mic ? lo_row : lo_col;
   end

   // pixel of the current tick
   always_comb begin
      sel = phase_ff[0];
      if (iacc_ff[IAW-1]) begin
         iclamp = '0;
      end else if (iacc_ff > IAW'({1'b1, {F{1'b0}}})) begin
         iclamp = {1'b1, {F{1'b0}}};
      end else begin
         iclamp = iacc_ff[F:0];
      end
      msum  = macc_ff + {{(MW-C-1-F){(mic_ff ? offr_ff[C] : offc_ff[C])}},
                         (mic_ff ? offr_ff : offc_ff), {F{1'b0}}};
      mbias = msum + {{(MW-F){1'b0}}, {F{msum[MW-1]}}};
      minor_pix = mbias[F+CW-1:F];
      dbias = dacc_ff + {{(DAW-F){1'b0}}, {F{dacc_ff[DAW-1]}}};
      major_pix = {mpos_ff[C], mpos_ff} + (mic_ff ? {offc_ff[C], offc_ff} : {offr_ff[C], offr_ff});
      plast = ($signed(mpos_ff) >= $signed(mend_ff));
      if (phase_ff == lrdi_pkg::PH_WALK) begin
         pcol    = mic_ff ? major_pix : minor_pix;
         prow    = mic_ff ? minor_pix : major_pix;
         pdep    = dbias[F+D-1:F];
         pix_int = iclamp;
      end else begin
         pcol    = {{2{ep_col_ff[sel][C-1]}}, ep_col_ff[sel]} + {offc_ff[C], offc_ff};
         prow    = {{2{ep_row_ff[sel][C-1]}}, ep_row_ff[sel]} + {offr_ff[C], offr_ff};
         pdep    = ep_dep_ff[sel];
         pix_int = ep_int_ff[sel];
         plast   = 1'b0;
      end
      pvis = !pcol[CW-1] && !prow[CW-1] &&
             (VW'(pcol[CW-2:0]) < VW'(bw_ff)) && (VW'(prow[CW-2:0]) < VW'(bh_ff));
      pr = color_ff[23:16] * pix_int;
      pg = color_ff[15:8]  * pix_int;
      pb = color_ff[7:0]   * pix_int;
   end

   // state update per queue transfer
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      mic_in    = mic_ff;
      mpos_in   = mpos_ff;
      mend_in   = mend_ff;
      macc_in   = macc_ff;
      dacc_in   = dacc_ff;
      iacc_in   = iacc_ff;
      mstep_in  = mstep_ff;
      dstep_in  = dstep_ff;
      istep_in  = istep_ff;
      if (take && is_start) begin
         active_in = 1'b1;
         phase_in  = lrdi_pkg::PH_A;
         mic_in    = e_mic;
         mpos_in   = e_mic ? {lo_col[C-1], lo_col} : {lo_row[C-1], lo_row};
         mend_in   = e_mic ? {hi_col[C-1], hi_col} : {hi_row[C-1], hi_row};
         macc_in   = {{(MW-C-F){lo_minor[C-1]}}, lo_minor, {F{1'b0}}};
         dacc_in   = lo ? {{2{e_b_dep[D-1]}}, e_b_dep, {F{1'b0}}}
                        : {{2{e_a_dep[D-1]}}, e_a_dep, {F{1'b0}}};
         iacc_in   = {2'b00, (lo ? e_b_int : e_a_int)};
         mstep_in  = e_min_step;
         dstep_in  = e_dep_step;
         istep_in  = e_int_step;
      end else if (emit) begin
         if (phase_ff == lrdi_pkg::PH_WALK) begin
            macc_in = macc_ff + {{(MW-F-2){mstep_ff[F+1]}}, mstep_ff};
            dacc_in = dacc_ff + dstep_ff;
            iacc_in = {2'b00, iclamp} + {istep_ff[F+1], istep_ff};
            mpos_in = mpos_ff + 1'b1;
            if (plast) active_in = 1'b0;
         end else begin
            phase_in = (phase_ff == lrdi_pkg::PH_A) ? lrdi_pkg::PH_B : lrdi_pkg::PH_WALK;
         end
      end
   end

   assign ov_in = emit || (ov_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff     <= lrdi_pkg::BUF_RESET;
         bh_ff     <= lrdi_pkg::BUF_RESET;
         den_ff    <= 1'b1;
         active_ff <= 1'b0;
         phase_ff  <= lrdi_pkg::PH_A;
         ov_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               lrdi_pkg::REG_BUF_WIDTH:  bw_ff  <= csr_wdata;
               lrdi_pkg::REG_BUF_HEIGHT: bh_ff  <= csr_wdata;
               lrdi_pkg::REG_DEPTH_EN:   den_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         active_ff <= active_in;
         phase_ff  <= phase_in;
         ov_ff     <= ov_in;
      end
      mic_ff   <= mic_in;
      mpos_ff  <= mpos_in;
      mend_ff  <= mend_in;
      macc_ff  <= macc_in;
      dacc_ff  <= dacc_in;
      iacc_ff  <= iacc_in;
      mstep_ff <= mstep_in;
      dstep_ff <= dstep_in;
      istep_ff <= istep_in;
      if (take && is_start) begin
         ep_col_ff[0] <= e_a_col;
         ep_row_ff[0] <= e_a_row;
         ep_dep_ff[0] <= e_a_dep;
         ep_int_ff[0] <= e_a_int;
         ep_col_ff[1] <= e_b_col;
         ep_row_ff[1] <= e_b_row;
         ep_dep_ff[1] <= e_b_dep;
         ep_int_ff[1] <= e_b_int;
         color_ff     <= e_color;
         offc_ff      <= e_offc;
         offr_ff      <= e_offr;
      end
      if (emit) begin
         o_col_ff  <= pcol;
         o_row_ff  <= prow;
         o_r_ff    <= pr[F+7:F];
         o_g_ff    <= pg[F+7:F];
         o_b_ff    <= pb[F+7:F];
         o_dep_ff  <= pdep;
         o_vis_ff  <= pvis;
         o_dw_ff   <= pvis && den_ff;
         o_last_ff <= plast;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_pix_col     = o_col_ff;
   assign rsp_pix_row     = o_row_ff;
   assign rsp_red         = o_r_ff;
   assign rsp_green       = o_g_ff;
   assign rsp_blue        = o_b_ff;
   assign rsp_depth       = o_dep_ff;
   assign rsp_visible     = o_vis_ff;
   assign rsp_depth_write = o_dw_ff;
   assign rsp_last        = o_last_ff;

   `LRDI_ASSERT_IMP(a_emit_room, clock, reset, emit, !ov_ff || rsp_ready, "pixel overwrites pending result")
endmodule
`default_nettype wire

// ===== src/line_raster_depth_intensity_core.sv =====
// line raster core: ticks on an active line emit one pixel per cycle when the
// output is ready; each passes through the queue and then the output register.
// a start item holds the input while the serial divider computes the three slopes.
// synchronous active-high reset: no line active, empty queue, registers at defaults.
`default_nettype none
module line_raster_depth_intensity_core #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16,
   parameter int DEPTH_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [12:0]                   csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_op,
   input  wire logic signed [COORD_BITS-1:0]  req_a_col,
   input  wire logic signed [COORD_BITS-1:0]  req_a_row,
   input  wire logic signed [DEPTH_BITS-1:0]  req_a_depth,
   input  wire logic signed [COORD_BITS-1:0]  req_b_col,
   input  wire logic signed [COORD_BITS-1:0]  req_b_row,
   input  wire logic signed [DEPTH_BITS-1:0]  req_b_depth,
   input  wire logic [8:0]                    req_a_intensity,
   input  wire logic [8:0]                    req_b_intensity,
   input  wire logic [23:0]                   req_base_color,
   input  wire logic signed [COORD_BITS:0]    req_offset_col,
   input  wire logic signed [COORD_BITS:0]    req_offset_row,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [COORD_BITS+1:0]       rsp_pix_col,
   output logic signed [COORD_BITS+1:0]       rsp_pix_row,
   output logic [7:0]                         rsp_red,
   output logic [7:0]                         rsp_green,
   output logic [7:0]                         rsp_blue,
   output logic signed [DEPTH_BITS-1:0]       rsp_depth,
   output logic                               rsp_visible,
   output logic                               rsp_depth_write,
   output logic                               rsp_last
);
   localparam int C  = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int D  = DEPTH_BITS;
   localparam int EW = 1 + 2 * (2 * C + D + F + 1) + 24 + 2 * (C + 1) + 2
                       + (F + 2) + (D + F + 2) + (F + 2);

   logic          q_push, q_full, q_pop, q_empty;
   logic [EW-1:0] q_wdata, q_rdata;

   lrdi_front #(.C(C), .F(F), .D(D), .EW(EW)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_a_col       (req_a_col),
      .req_a_row       (req_a_row),
      .req_a_depth     (req_a_depth),
      .req_b_col       (req_b_col),
      .req_b_row       (req_b_row),
      .req_b_depth     (req_b_depth),
      .req_a_intensity (req_a_intensity),
      .req_b_intensity (req_b_intensity),
      .req_base_color  (req_base_color),
      .req_offset_col  (req_offset_col),
      .req_offset_row  (req_offset_row),
      .q_push          (q_push),
      .q_data          (q_wdata),
      .q_full          (q_full)
   );

   lrdi_fifo #(.WIDTH(EW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   lrdi_back #(.C(C), .F(F), .D(D), .EW(EW)) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_empty         (q_empty),
      .q_data          (q_rdata),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pix_col     (rsp_pix_col),
      .rsp_pix_row     (rsp_pix_row),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_depth       (rsp_depth),
      .rsp_visible     (rsp_visible),
      .rsp_depth_write (rsp_depth_write),
      .rsp_last        (rsp_last)
   );
endmodule
`default_nettype wire

// ===== test/line_raster_depth_intensity_core_checker.sv =====
// pixel checker for the line raster core: watches the csr port and both channels,
// predicts each pixel from its own copy of the line state and compares in order
// depends on lrdi_pkg for register indexes, opcodes and reset and intensity constants
module line_raster_depth_intensity_core_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [12:0]        csr_wdata,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_op,
   input  wire logic signed [11:0] req_a_col,
   input  wire logic signed [11:0] req_a_row,
   input  wire logic signed [15:0] req_a_depth,
   input  wire logic signed [11:0] req_b_col,
   input  wire logic signed [11:0] req_b_row,
   input  wire logic signed [15:0] req_b_depth,
   input  wire logic [8:0]         req_a_intensity,
   input  wire logic [8:0]         req_b_intensity,
   input  wire logic [23:0]        req_base_color,
   input  wire logic signed [12:0] req_offset_col,
   input  wire logic signed [12:0] req_offset_row,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [13:0] rsp_pix_col,
   input  wire logic signed [13:0] rsp_pix_row,
   input  wire logic [7:0]         rsp_red,
   input  wire logic [7:0]         rsp_green,
   input  wire logic [7:0]         rsp_blue,
   input  wire logic signed [15:0] rsp_depth,
   input  wire logic               rsp_visible,
   input  wire logic               rsp_depth_write,
   input  wire logic               rsp_last,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE_FX = 64'sd65536;

   typedef struct packed {
      logic [13:0] col;
      logic [13:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] depth;
      logic        visible;
      logic        depth_write;
      logic        last;
   } pixel_type;

   pixel_type pixel_q[$];

   // shadow registers
   logic [12:0] buf_width, buf_height;
   logic        depth_en;

   // shadow line state
   bit     line_on, col_major;
   int     phase;
   longint walk_pos, walk_end;
   longint minor_fx, minor_inc, depth_fx, depth_inc, shade_fx, shade_inc;
   longint ep_col[2], ep_row[2], ep_depth[2], ep_shade[2];
   logic [23:0] line_color;
   longint off_col, off_row;

   function automatic longint trunc_fx(longint v);
      if (v >= 0) return v >>> 16;
      return -((-v) >>> 16);
   endfunction

   function automatic longint slope_fx(longint delta, longint len);
      if (len <= 0) return 0;
      return (delta * ONE_FX) / len;
   endfunction

   function automatic logic [7:0] scale_channel(logic [7:0] ch, longint shade);
      longint prod;
      prod = longint'(ch) * shade;
      return 8'(prod >>> 16);
   endfunction

   function automatic pixel_type make_pixel(longint col, longint row, longint dep,
                                            longint shade, bit last);
      pixel_type p;
      bit vis;
      vis = col >= 0 && col < longint'(buf_width) && row >= 0 && row < longint'(buf_height);
      p.col = 14'(col);
      p.row = 14'(row);
      p.red = scale_channel(line_color[23:16], shade);
      p.green = scale_channel(line_color[15:8], shade);
      p.blue = scale_channel(line_color[7:0], shade);
      p.depth = 16'(dep);
      p.visible = vis;
      p.depth_write = vis && depth_en;
      p.last = last;
      return p;
   endfunction

   // load a new line from a start transfer
   task automatic load_line();
      longint ia, ib, dc, dr, adc, adr, len;
      int lo, hi;
      ia = req_a_intensity > lrdi_pkg::INTEN_MAX ? 256 : req_a_intensity;
      ib = req_b_intensity > lrdi_pkg::INTEN_MAX ? 256 : req_b_intensity;
      ep_col[0] = req_a_col;  ep_row[0] = req_a_row;  ep_depth[0] = req_a_depth;
      ep_col[1] = req_b_col;  ep_row[1] = req_b_row;  ep_depth[1] = req_b_depth;
      ep_shade[0] = ia * 256;
      ep_shade[1] = ib * 256;
      line_color = req_base_color;
      off_col = req_offset_col;
      off_row = req_offset_row;
      dc = ep_col[1] - ep_col[0];
      dr = ep_row[1] - ep_row[0];
      adc = dc < 0 ? -dc : dc;
      adr = dr < 0 ? -dr : dr;
      col_major = !(adr > adc);
      lo = 0;
      hi = 1;
      if (col_major ? (dc < 0) : (dr < 0)) begin
         lo = 1;
         hi = 0;
      end
      len = col_major ? adc : adr;
      if (col_major) begin
         walk_pos = ep_col[lo];
         walk_end = ep_col[hi];
         minor_fx = ep_row[lo] * ONE_FX;
         minor_inc = slope_fx(ep_row[hi] - ep_row[lo], len);
      end else begin
         walk_pos = ep_row[lo];
         walk_end = ep_row[hi];
         minor_fx = ep_col[lo] * ONE_FX;
         minor_inc = slope_fx(ep_col[hi] - ep_col[lo], len);
      end
      depth_inc = slope_fx(ep_depth[hi] - ep_depth[lo], len);
      shade_inc = slope_fx(ep_shade[hi] - ep_shade[lo], len) / ONE_FX;
      depth_fx = ep_depth[lo] * ONE_FX;
      shade_fx = ep_shade[lo];
      phase = 0;
      line_on = 1;
   endtask

   // one tick: endpoint pixels first, then the walk
   task automatic tick_line();
      longint col, row;
      bit last;
      if (!line_on) return;
      if (phase < 2) begin
         pixel_q.push_back(make_pixel(ep_col[phase] + off_col, ep_row[phase] + off_row,
                                      ep_depth[phase], ep_shade[phase], 0));
         phase++;
         return;
      end
      last = walk_pos >= walk_end;
      if (shade_fx < 0) shade_fx = 0;
      if (shade_fx > ONE_FX) shade_fx = ONE_FX;
      if (col_major) begin
         col = walk_pos + off_col;
         row = trunc_fx(minor_fx + off_row * ONE_FX);
      end else begin
         row = walk_pos + off_row;
         col = trunc_fx(minor_fx + off_col * ONE_FX);
      end
      pixel_q.push_back(make_pixel(col, row, trunc_fx(depth_fx), shade_fx, last));
      minor_fx += minor_inc;
      depth_fx += depth_inc;
      shade_fx += shade_inc;
      walk_pos++;
      if (last) line_on = 0;
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t pixel %s mismatch: expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // compare one result transfer against the oldest prediction
   task automatic check_pixel();
      pixel_type want;
      if (pixel_q.size() == 0) begin
         $display("%0t unexpected pixel: expected none actual col %0d row %0d",
                  $time, rsp_pix_col, rsp_pix_row);
         fail_count++;
         return;
      end
      want = pixel_q.pop_front();
      check_field("col", $signed(want.col), rsp_pix_col);
      check_field("row", $signed(want.row), rsp_pix_row);
      check_field("red", want.red, rsp_red);
      check_field("green", want.green, rsp_green);
      check_field("blue", want.blue, rsp_blue);
      check_field("depth", $signed(want.depth), rsp_depth);
      check_field("visible", want.visible, rsp_visible);
      check_field("depth_write", want.depth_write, rsp_depth_write);
      check_field("last", want.last, rsp_last);
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // sample all ports at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         pixel_q.delete();
         buf_width = lrdi_pkg::BUF_RESET;
         buf_height = lrdi_pkg::BUF_RESET;
         depth_en = 1;
         line_on = 0;
         phase = 0;
         line_color = 0;
         off_col = 0;
         off_row = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               lrdi_pkg::REG_BUF_WIDTH: buf_width = csr_wdata;
               lrdi_pkg::REG_BUF_HEIGHT: buf_height = csr_wdata;
               lrdi_pkg::REG_DEPTH_EN: depth_en = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_op == lrdi_pkg::OP_START) load_line();
            else tick_line();
         end
         if (rsp_valid && rsp_ready) check_pixel();
      end
      pending = pixel_q.size();
   end
endmodule

// ===== test/line_raster_depth_intensity_core_tb.sv =====
// top of the line raster core testbench: clock, reset, line stimulus, csr phases
// depends on lrdi_pkg, the core and line_raster_depth_intensity_core_checker
module line_raster_depth_intensity_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic               op;
      logic signed [11:0] a_col, a_row;
      logic signed [15:0] a_depth;
      logic signed [11:0] b_col, b_row;
      logic signed [15:0] b_depth;
      logic [8:0]         a_inten, b_inten;
      logic [23:0]        color;
      logic signed [12:0] off_col, off_row;
   } line_item_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [1:0] csr_index = '0;
   logic [12:0] csr_wdata = '0;
   logic req_valid = 0, req_op = lrdi_pkg::OP_TICK;
   logic signed [11:0] req_a_col = '0, req_a_row = '0, req_b_col = '0, req_b_row = '0;
   logic signed [15:0] req_a_depth = '0, req_b_depth = '0;
   logic [8:0] req_a_intensity = '0, req_b_intensity = '0;
   logic [23:0] req_base_color = '0;
   logic signed [12:0] req_offset_col = '0, req_offset_row = '0;
   logic rsp_ready = 0;
   wire logic req_ready, rsp_valid;
   wire logic signed [13:0] rsp_pix_col, rsp_pix_row;
   wire logic [7:0] rsp_red, rsp_green, rsp_blue;
   wire logic signed [15:0] rsp_depth;
   wire logic rsp_visible, rsp_depth_write, rsp_last;
   int fail_count, pending;

   int send_idle_pct = 0, recv_idle_pct = 0;
   bit hold_req = 0;
   int stall_cycles = 0;
   line_item_type cur;

   always #6 clock = ~clock;

   line_raster_depth_intensity_core dut (.*);
   line_raster_depth_intensity_core_checker pixel_check (.*);

   // offer one item, idling the sender at random first
   task automatic offer_item(input line_item_type it);
      while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_op <= it.op;
      req_a_col <= it.a_col;     req_a_row <= it.a_row;     req_a_depth <= it.a_depth;
      req_b_col <= it.b_col;     req_b_row <= it.b_row;     req_b_depth <= it.b_depth;
      req_a_intensity <= it.a_inten;
      req_b_intensity <= it.b_inten;
      req_base_color <= it.color;
      req_offset_col <= it.off_col;
      req_offset_row <= it.off_row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_ticks(input int n);
      line_item_type t;
      t = cur;
      t.op = lrdi_pkg::OP_TICK;
      repeat (n) offer_item(t);
   endtask

   // ticks that cover both endpoints and the full walk
   function automatic int full_ticks(input line_item_type it);
      int dc, dr;
      dc = it.b_col - it.a_col;
      dr = it.b_row - it.a_row;
      if (dc < 0) dc = -dc;
      if (dr < 0) dr = -dr;
      return 3 + (dc > dr ? dc : dr);
   endfunction

   task automatic start_line(input line_item_type it);
      cur = it;
      cur.op = lrdi_pkg::OP_START;
      offer_item(cur);
   endtask

   // wait until every predicted pixel is out, then let the divider settle
   task automatic drain();
      req_valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [12:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 0;
      @(negedge clock);
   endtask

   task automatic set_buffer(input int w, input int h, input bit den);
      csr_write(lrdi_pkg::REG_BUF_WIDTH, 13'(w));
      csr_write(lrdi_pkg::REG_BUF_HEIGHT, 13'(h));
      csr_write(lrdi_pkg::REG_DEPTH_EN, 13'(den));
   endtask

   function automatic line_item_type random_line();
      line_item_type it;
      it.op = lrdi_pkg::OP_START;
      it.a_col = 12'($urandom_range(0, 4095));
      it.a_row = 12'($urandom_range(0, 4095));
      it.a_depth = 16'($urandom_range(0, 65535));
      it.b_depth = 16'($urandom_range(0, 65535));
      it.a_inten = 9'($urandom_range(0, 511));
      it.b_inten = 9'($urandom_range(0, 511));
      if ($urandom_range(0, 3) == 0) it.a_inten = 9'($urandom_range(0, 256));
      it.color = 24'($urandom);
      it.off_col = 13'($urandom_range(0, 8191));
      it.off_row = 13'($urandom_range(0, 8191));
      if ($urandom_range(1, 100) <= 85) begin
         // short line near a random point so the walk completes
         it.b_col = it.a_col + 12'($urandom_range(0, 40)) - 12'd20;
         it.b_row = it.a_row + 12'($urandom_range(0, 40)) - 12'd20;
         if ($urandom_range(0, 9) == 0) it.b_col = it.a_col;
         if ($urandom_range(0, 9) == 0) it.b_row = it.a_row;
         if ($urandom_range(0, 2) == 0) begin
            // keep pixels mostly on screen
            it.off_col = 13'($urandom_range(0, 400));
            it.off_row = 13'($urandom_range(0, 400));
            it.a_col = 12'($urandom_range(0, 200));
            it.a_row = 12'($urandom_range(0, 200));
            it.b_col = it.a_col + 12'($urandom_range(0, 30));
            it.b_row = it.a_row + 12'($urandom_range(0, 30));
         end
      end else begin
         it.b_col = 12'($urandom_range(0, 4095));
         it.b_row = 12'($urandom_range(0, 4095));
      end
      return it;
   endfunction

   // random lines: mostly complete walks, some aborted, some with idle ticks
   task automatic random_lines(input int items);
      int sent, n;
      line_item_type it;
      sent = 0;
      while (sent < items) begin
         it = random_line();
         start_line(it);
         n = full_ticks(it);
         case ($urandom_range(0, 9))
            0: n = $urandom_range(0, 4);
            1: n = n + $urandom_range(1, 3);
            default: if (n > 60) n = $urandom_range(3, 20);
         endcase
         send_ticks(n);
         sent += n + 1;
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_ready <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= !(recv_idle_pct > 0 && $urandom_range(1, 100) <= recv_idle_pct);
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("line_raster_depth_intensity_core test failed");
            $finish;
         end
      end
   end

   initial begin
      line_item_type it;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: tick while idle, degenerate line, steep and reversed lines
      set_buffer(640, 480, 1);
      csr_write(REG_SPARE, 13'h1fff);
      cur = '{default: '0};
      cur.op = lrdi_pkg::OP_TICK;
      send_ticks(1);
      start_line('{lrdi_pkg::OP_START, 12'sd5, 12'sd5, 16'sd100, 12'sd5, 12'sd5, 16'sd100,
                   9'd128, 9'd128, 24'hffffff, 13'sd0, 13'sd0});
      send_ticks(4);
      start_line('{lrdi_pkg::OP_START, 12'sd10, 12'sd40, -16'sd32768, 12'sd13, 12'sd20,
                   16'sd32767, 9'd511, 9'd0, 24'h80ff01, 13'sd3, -13'sd4});
      send_ticks(8);
      start_line('{lrdi_pkg::OP_START, -12'sd2048, -12'sd2048, 16'sd32767, 12'sd2047,
                   12'sd2047, -16'sd32768, 9'd256, 9'd257, 24'hffffff, 13'sd4095,
                   -13'sd4096});
      send_ticks(4);
      start_line('{lrdi_pkg::OP_START, 12'sd2047, 12'sd0, 16'sd0, 12'sd2040, 12'sd3,
                   -16'sd1, 9'd0, 9'd256, 24'h010203, -13'sd4096, 13'sd4095});
      send_ticks(11);
      drain();

      // phase one: slow receiver
      set_buffer(1, 4096, 0);
      send_idle_pct = 23;
      recv_idle_pct = 85;
      random_lines(200);
      drain();

      // phase two: slow sender
      set_buffer(4096, 1, 1);
      send_idle_pct = 85;
      recv_idle_pct = 23;
      random_lines(200);
      drain();

      // phase three: full rate, long hold-off while ticks keep coming
      set_buffer(300, 300, 1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      it = random_line();
      it.a_col = 12'sd0;  it.a_row = 12'sd0;
      it.b_col = 12'sd300; it.b_row = 12'sd97;
      start_line(it);
      hold_req = 1;
      send_ticks(303);
      drain();
      set_buffer(4096, 4096, 0);
      random_lines(200);
      drain();

      if (fail_count == 0)
         $display("line_raster_depth_intensity_core test passed");
      else
         $display("line_raster_depth_intensity_core test failed");
      $finish;
   end
endmodule
